// ----- src/led_strip_effect_generator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// LED strip effect generator assertion macros
// Concurrent assertion shorthands used by the checker file lseg_checker.sv.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_EFFECT_GENERATOR_UNIT_MACROS_SVH
`define LED_STRIP_EFFECT_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSEG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LSEG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/lseg_pkg.sv -----
// ----------------------------------------------------------------------------
// lseg_pkg
// Shared types and constants of the LED strip effect generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lseg_pkg;

   localparam int MAX_LEDS = 256;

   localparam int RSP_DEPTH = 4;
   localparam int ADDR_W    = 5;

   // effect codes
   localparam logic [2:0] MODE_OFF    = 3'd0;
   localparam logic [2:0] MODE_SOLID  = 3'd1;
   localparam logic [2:0] MODE_FLASH  = 3'd2;
   localparam logic [2:0] MODE_BREATH = 3'd3;
   localparam logic [2:0] MODE_SCAN   = 3'd4;

   // register indexes (word address)
   localparam logic [2:0] REG_EFFECT_MODE  = 3'd0;
   localparam logic [2:0] REG_MAIN_COLOR   = 3'd1;
   localparam logic [2:0] REG_SECOND_COLOR = 3'd2;
   localparam logic [2:0] REG_STEP_PERIOD  = 3'd3;
   localparam logic [2:0] REG_STRIP_LENGTH = 3'd4;

   localparam logic UPD_FILL  = 1'b0;
   localparam logic UPD_PIXEL = 1'b1;

   typedef struct packed {
      logic tick;
      logic restart;
   } req_type;

   typedef struct packed {
      logic       update_kind;
      logic [7:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  effect_mode;
      logic [23:0] main_color;
      logic [23:0] second_color;
      logic [7:0]  step_period_ms;
      logic [8:0]  strip_length;
   } cfg_type;

   // up to two results produced by one item
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

// ----- src/lseg_csr.sv -----
// ----------------------------------------------------------------------------
// lseg_csr
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module lseg_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [lseg_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output      logic [31:0]                 prdata,
   output      lseg_pkg::cfg_type           cfg
);

   lseg_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index = paddr[lseg_pkg::ADDR_W-1:2];
   assign wr_en = psel & penable & pwrite;
   assign cfg   = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            lseg_pkg::REG_EFFECT_MODE:  cfg_in.effect_mode    = pwdata[2:0];
            lseg_pkg::REG_MAIN_COLOR:   cfg_in.main_color     = pwdata[23:0];
            lseg_pkg::REG_SECOND_COLOR: cfg_in.second_color   = pwdata[23:0];
            lseg_pkg::REG_STEP_PERIOD:  cfg_in.step_period_ms = pwdata[7:0];
            lseg_pkg::REG_STRIP_LENGTH: cfg_in.strip_length   = pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.effect_mode    <= lseg_pkg::MODE_OFF;
         cfg_ff.main_color     <= '0;
         cfg_ff.second_color   <= '0;
         cfg_ff.step_period_ms <= '0;
         cfg_ff.strip_length   <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         lseg_pkg::REG_EFFECT_MODE:  prdata = {29'd0, cfg_ff.effect_mode};
         lseg_pkg::REG_MAIN_COLOR:   prdata = {8'd0, cfg_ff.main_color};
         lseg_pkg::REG_SECOND_COLOR: prdata = {8'd0, cfg_ff.second_color};
         lseg_pkg::REG_STEP_PERIOD:  prdata = {24'd0, cfg_ff.step_period_ms};
         lseg_pkg::REG_STRIP_LENGTH: prdata = {23'd0, cfg_ff.strip_length};
         default:                    prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/lseg_core.sv -----
// ----------------------------------------------------------------------------
// lseg_core
// Effect state and per-item result generation, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lseg_core #(
   parameter int MAX_LEDS = lseg_pkg::MAX_LEDS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire lseg_pkg::req_type  item,
   input  wire lseg_pkg::cfg_type  cfg,
   output      lseg_pkg::push_type push
);

   // usable pixel count never exceeds the 8-bit pixel index range
   localparam logic [8:0] LEN_CAP = 9'((MAX_LEDS < 256) ? MAX_LEDS : 256);

   logic       running_ff, running_in;
   logic       phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] hold_ff, hold_in;

   logic [7:0] period;
   logic       period_end;
   logic       animated;
   logic       frame;
   logic [8:0] len_clip;
   logic [7:0] scan_last;
   logic [23:0] breath_rgb;

   // s + lvl*(e-s)/255 truncated toward zero; x/255 = (x + 1 + x>>8) >> 8
   function automatic logic [7:0] blend(input logic [7:0] s, input logic [7:0] e,
                                        input logic [7:0] lvl);
      logic [7:0]  diff;
      logic [15:0] prod;
      logic [16:0] q;
      logic [7:0]  quot;
      diff = (e >= s) ? (e - s) : (s - e);
      prod = lvl * diff;
      q    = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
      quot = q[15:8];
      return (e >= s) ? (s + quot) : (s - quot);
   endfunction

   assign period     = (cfg.step_period_ms == 8'd0) ? 8'd1 : cfg.step_period_ms;
   assign period_end = ({1'b0, hold_ff} + 9'd1) >= {1'b0, period};
   assign animated   = cfg.effect_mode inside {lseg_pkg::MODE_FLASH,
                                               lseg_pkg::MODE_BREATH,
                                               lseg_pkg::MODE_SCAN};

   always_comb begin
      len_clip = (cfg.strip_length == 9'd0) ? 9'd1 : cfg.strip_length;
      if (len_clip > LEN_CAP) begin
         len_clip = LEN_CAP;
      end
      scan_last = 8'(len_clip - 9'd1);
   end

   // next state
   always_comb begin
      running_in = running_ff;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      hold_in    = hold_ff;
      frame      = 1'b0;
      if (fire) begin
         if (item.restart) begin
            running_in = 1'b1;
            phase_in   = 1'b0;
            pos_in     = '0;
            hold_in    = '0;
         end else if (item.tick && running_ff && animated) begin
            if (!period_end) begin
               hold_in = hold_ff + 8'd1;
            end else begin
               hold_in = '0;
               frame   = 1'b1;
               case (cfg.effect_mode)
                  lseg_pkg::MODE_FLASH: begin
                     phase_in = ~phase_ff;
                  end
                  lseg_pkg::MODE_BREATH: begin
                     if (!phase_ff) begin
                        if (pos_ff == 8'd255) phase_in = 1'b1;
                        else                  pos_in   = pos_ff + 8'd1;
                     end else begin
                        if (pos_ff == 8'd0) phase_in = 1'b0;
                        else                pos_in   = pos_ff - 8'd1;
                     end
                  end
                  lseg_pkg::MODE_SCAN: begin
                     // length shrank under the pixel: snap to the end, turn back
                     if (pos_ff > scan_last) begin
                        pos_in   = scan_last;
                        phase_in = 1'b1;
                     end else if (!phase_ff) begin
                        if (pos_ff == scan_last) phase_in = 1'b1;
                        else                     pos_in   = pos_ff + 8'd1;
                     end else begin
                        if (pos_ff == 8'd0) phase_in = 1'b0;
                        else                pos_in   = pos_ff - 8'd1;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         phase_ff   <= 1'b0;
         pos_ff     <= '0;
         hold_ff    <= '0;
      end else begin
         running_ff <= running_in;
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         hold_ff    <= hold_in;
      end
   end

   assign breath_rgb = {blend(cfg.main_color[23:16], cfg.second_color[23:16], pos_in),
                        blend(cfg.main_color[15:8],  cfg.second_color[15:8],  pos_in),
                        blend(cfg.main_color[7:0],   cfg.second_color[7:0],   pos_in)};

   // results
   always_comb begin
      push.count              = 2'd0;
      push.first              = '0;
      push.first.update_kind  = lseg_pkg::UPD_FILL;
      push.first.last         = 1'b1;
      push.second             = '0;
      push.second.update_kind = lseg_pkg::UPD_PIXEL;
      push.second.last        = 1'b1;
      if (fire && item.restart) begin
         push.count = 2'd1;
         case (cfg.effect_mode)
            lseg_pkg::MODE_SOLID, lseg_pkg::MODE_FLASH, lseg_pkg::MODE_BREATH: begin
               // breath level zero is the start color itself
               {push.first.red, push.first.green, push.first.blue} = cfg.main_color;
            end
            lseg_pkg::MODE_SCAN: begin
               push.first.update_kind = lseg_pkg::UPD_PIXEL;
               {push.first.red, push.first.green, push.first.blue} = cfg.main_color;
            end
            default: ;
         endcase
      end else if (frame) begin
         push.count = 2'd1;
         case (cfg.effect_mode)
            lseg_pkg::MODE_FLASH: begin
               if (!phase_in) begin
                  {push.first.red, push.first.green, push.first.blue} = cfg.main_color;
               end
            end
            lseg_pkg::MODE_BREATH: begin
               {push.first.red, push.first.green, push.first.blue} = breath_rgb;
            end
            lseg_pkg::MODE_SCAN: begin
               // clear the old pixel, then light the new one
               push.count              = 2'd2;
               push.first.update_kind  = lseg_pkg::UPD_PIXEL;
               push.first.pixel_index  = pos_ff;
               push.first.last         = 1'b0;
               push.second.pixel_index = pos_in;
               {push.second.red, push.second.green, push.second.blue} = cfg.main_color;
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- src/lseg_fifo.sv -----
// ----------------------------------------------------------------------------
// lseg_fifo
// Result queue taking up to two words per cycle and giving one when rsp_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lseg_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lseg_pkg::push_type push,
   output      logic               room,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      lseg_pkg::rsp_type  rsp_data
);

   localparam int PTR_W = $clog2(lseg_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(lseg_pkg::RSP_DEPTH + 1);

   lseg_pkg::rsp_type mem [lseg_pkg::RSP_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic             pop;

   assign pop       = rsp_valid & rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];
   // a new item may bring two words
   assign room      = (count_ff <= CNT_W'(lseg_pkg::RSP_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = pop ? (rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ----- src/led_strip_effect_generator_unit.sv -----
// An accepted item waits in the input register for queue room; its results are
// then written into the queue. Throughput: one item per cycle while the queue
// has room; a scan frame change gives two words, drained at one word per cycle
// while rsp_ready is high, through a four-word queue. Ready drops only while
// the input register holds an item and the queue has room for under two words.
// Sync reset clears the effect state, queue and registers (strip_length to 256).
// ----------------------------------------------------------------------------
// led_strip_effect_generator_unit
// Off, solid, flash, breath and scan strip effects driven by millisecond ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_effect_generator_unit #(
   parameter int MAX_LEDS = lseg_pkg::MAX_LEDS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire lseg_pkg::req_type           req_data,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      lseg_pkg::rsp_type           rsp_data,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [lseg_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output      logic [31:0]                 prdata,
   output      logic                        pready
);

   lseg_pkg::cfg_type  cfg;
   lseg_pkg::push_type push;
   lseg_pkg::req_type  item_ff;
   logic               in_valid_ff, in_valid_in;
   logic               room;
   logic               fire;

   assign pready    = 1'b1;
   assign fire      = in_valid_ff & room;
   assign req_ready = ~in_valid_ff | room;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   lseg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   lseg_core #(
      .MAX_LEDS (MAX_LEDS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item_ff),
      .cfg   (cfg),
      .push  (push)
   );

   lseg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/lseg_checker.sv -----
// ----------------------------------------------------------------------------
// lseg_checker
// Port-level checks of the effect generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_strip_effect_generator_unit_macros.svh"

module lseg_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire lseg_pkg::rsp_type rsp_data
);

   logic stalled;
   logic clear_word;

   assign stalled    = rsp_valid & ~rsp_ready;
   assign clear_word = rsp_valid & ~rsp_data.last;

   `LSEG_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")
   `LSEG_ASSERT_NOW(a_clear_is_pixel, clock, reset, clear_word, rsp_data.update_kind == lseg_pkg::UPD_PIXEL, "non-final word is not a pixel write")
   `LSEG_ASSERT_NOW(a_clear_is_black, clock, reset, clear_word, (rsp_data.red == 8'd0) && (rsp_data.green == 8'd0) && (rsp_data.blue == 8'd0), "pixel clear is not black")
   `LSEG_ASSERT_NOW(a_fill_index, clock, reset, rsp_valid && (rsp_data.update_kind == lseg_pkg::UPD_FILL), rsp_data.pixel_index == 8'd0, "fill carries a pixel index")
   `LSEG_ASSERT_NEXT(a_clear_then_light, clock, reset, clear_word && rsp_ready, rsp_valid && rsp_data.last && (rsp_data.update_kind == lseg_pkg::UPD_PIXEL), "pixel clear not followed by pixel light")

endmodule

bind led_strip_effect_generator_unit lseg_checker u_lseg_checker (.*);

`default_nettype wire
